FILE: hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared sizes, payload types and the controller command word.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int RANK_W     = IDX_W;
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;

  typedef logic signed [KEY_BITS-1:0]   key_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [RANK_W-1:0]            rank_t;
  typedef logic [OCC_W-1:0]             occ_t;
  typedef logic [CAP_W-1:0]             cap_t;

  // operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input word
    logic search;   // register the associative lookup results
    logic commit;   // write back state and load the output word
  } lkvc_cmd_t;

endpackage

FILE: hw/rtl/lkvc_in_if.sv
// ----------------------------------------------------------------------------
// LRU cache request channel
// Valid/ready channel carrying one get or put request word.
// ----------------------------------------------------------------------------
interface lkvc_in_if;
  import lkvc_pkg::*;

  logic valid;
  logic ready;
  logic operation;
  key_t key;
  val_t value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);

endinterface

FILE: hw/rtl/lkvc_out_if.sv
// ----------------------------------------------------------------------------
// LRU cache response channel
// Valid/ready channel carrying one response word per request.
// ----------------------------------------------------------------------------
interface lkvc_out_if;
  import lkvc_pkg::*;

  logic valid;
  logic ready;
  logic hit;
  val_t read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);

endinterface

FILE: hw/rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU cache controller
// Sequences capture, lookup and write-back; owns the response valid flag.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lkvc_pkg::lkvc_cmd_t cmd
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // response slot frees up when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_UPDATE) && out_free);
  assign out_valid = out_valid_r;

  // commands
  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.search  = (state_r == S_LOOKUP);
    cmd.commit  = (state_r == S_UPDATE) && out_free;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (cmd.commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = cmd.capture ? S_LOOKUP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a commit always presents a response word next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise response valid");

  // a new word is never taken while a lookup is pending
  a_no_capture_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> !cmd.capture)
    else $error("request captured during lookup");

endmodule

FILE: hw/rtl/lkvc_dpath.sv
// ----------------------------------------------------------------------------
// LRU cache datapath
// Entry store, associative compare, recency ranks and response register.
// ----------------------------------------------------------------------------
module lkvc_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  lkvc_pkg::lkvc_cmd_t cmd,
  input  logic                cfg_we,
  input  lkvc_pkg::cap_t      cfg_wdata,
  input  logic                in_operation,
  input  lkvc_pkg::key_t      in_key,
  input  lkvc_pkg::val_t      in_value,
  output logic                out_hit,
  output lkvc_pkg::val_t      out_read_value
);
  import lkvc_pkg::*;

  // configuration
  cap_t cap_r;
  occ_t eff_cap;

  // entry store
  logic [ENTRIES-1:0] valid_r;
  key_t               key_r  [ENTRIES];
  val_t               val_r  [ENTRIES];
  rank_t              rank_r [ENTRIES];
  rank_t              rank_nxt [ENTRIES];
  occ_t               occ_r;

  // captured request
  logic op_r;
  key_t req_key_r;
  val_t req_val_r;

  // lookup results
  logic  hit_c, free_c, victim_c;
  idx_t  hit_idx_c, free_idx_c, victim_idx_c;
  logic  hit_r, ins_ok_r;
  idx_t  hit_idx_r, free_idx_r, victim_idx_r;
  rank_t hit_rank_r;

  // write-back control
  logic is_put;
  logic wr_val_en, wr_key_en, do_insert;
  idx_t wr_idx;
  logic touch_en;
  occ_t touch_lim;

  // response register
  logic out_hit_r;
  val_t out_read_value_r;

  // capacity register; the effective capacity is clamped to 1 .. ENTRIES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(ENTRIES);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = OCC_W'(1);
    end else if (OCC_W'(cap_r) > OCC_W'(ENTRIES)) begin
      eff_cap = OCC_W'(ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_r);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_operation;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
  end

  // associative compare, first free slot, least recent entry
  always_comb begin
    hit_c        = 1'b0;
    hit_idx_c    = '0;
    free_c       = 1'b0;
    free_idx_c   = '0;
    victim_c     = 1'b0;
    victim_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == req_key_r)) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = IDX_W'(i);
      end
      // ranks are distinct 0 .. occ-1, so the oldest holds occ-1
      if (valid_r[i] && (OCC_W'(rank_r[i]) == occ_r - OCC_W'(1))) begin
        victim_c     = 1'b1;
        victim_idx_c = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r        <= hit_c;
      hit_idx_r    <= hit_idx_c;
      hit_rank_r   <= rank_r[hit_idx_c];
      ins_ok_r     <= free_c && (occ_r < eff_cap);
      free_idx_r   <= free_idx_c;
      victim_idx_r <= victim_idx_c;
    end
  end

  // low when no valid entry matches the oldest rank; only gates eviction
  logic victim_r;
  always_ff @(posedge clk) begin
    if (cmd.search) victim_r <= victim_c;
  end

  // write-back decode
  always_comb begin
    is_put    = (op_r == OP_PUT);
    do_insert = !hit_r && is_put && ins_ok_r;
    wr_key_en = !hit_r && is_put && (ins_ok_r || victim_r);
    wr_val_en = (hit_r && is_put) || wr_key_en;
    touch_en  = hit_r || wr_key_en;
    if (hit_r) begin
      wr_idx    = hit_idx_r;
      touch_lim = OCC_W'(hit_rank_r);
    end else if (ins_ok_r) begin
      wr_idx    = free_idx_r;
      touch_lim = OCC_W'(ENTRIES);
    end else begin
      wr_idx    = victim_idx_r;
      touch_lim = occ_r - OCC_W'(1);
    end
  end

  // recency update: touched entry goes to 0, younger ones age by one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (touch_en) begin
        if (IDX_W'(i) == wr_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (OCC_W'(rank_r[i]) < touch_lim)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
  end

  // control state of the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else if (cmd.commit) begin
      if (do_insert) begin
        valid_r[wr_idx] <= 1'b1;
        occ_r           <= occ_r + OCC_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  // key and value payload, single write port
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_key_en) key_r[wr_idx] <= req_key_r;
    if (cmd.commit && wr_val_en) val_r[wr_idx] <= req_val_r;
  end

  // response word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r        <= hit_r;
      out_read_value_r <= (hit_r && !is_put) ? val_r[hit_idx_r] : '0;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

  // occupancy tracks the number of valid entries
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match valid entries");

  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(ENTRIES))
    else $error("occupancy above entry count");

  // a touched entry becomes most recent
  a_touch_mru: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && touch_en) |=> (rank_r[$past(wr_idx)] == '0))
    else $error("touched entry not most recent");

endmodule

FILE: hw/rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request word (get or put) returns one response word. An accepted word
// passes the lookup state (16-way key compare and slot encode into registers)
// then the write-back state (rank update, store write, response load), which
// waits for the previous response to drain. A new request can be taken in the
// write-back of the previous one, and a request is accepted while the previous
// response still waits in its register. Reset empties the store at once
// through per-entry valid bits; no clearing pass. cfg_wdata sets the capacity
// (0 acts as 1, above 16 as 16); the user must write it only while the block
// is idle (not enforced by the block); lowering it evicts nothing at once.
module lru_key_value_cache_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  lkvc_pkg::cap_t      cfg_wdata,
  lkvc_in_if.sink             in_ch,
  lkvc_out_if.source          out_ch
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;

  // controller
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath
  lkvc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_operation   (in_ch.operation),
    .in_key         (in_ch.key),
    .in_value       (in_ch.value),
    .out_hit        (out_ch.hit),
    .out_read_value (out_ch.read_value)
  );

endmodule
